### hw/rtl/tdd_pkg.sv
// Package for the tile deduplicator: word types and sizing constants.
`timescale 1ns / 1ps

package tdd_pkg;

  localparam int MAX_TILES_DEF = 256;
  localparam int TILE_ROWS     = 8;
  localparam int ROW_W         = 64;

  typedef struct packed {
    logic [ROW_W-1:0] row_pixels;
    logic             end_of_image;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tile_index;
    logic       is_new;
    logic [8:0] tile_count;
    logic       overflow;
  } out_word_t;

endpackage

### hw/rtl/tile_deduplicator.sv
// Tile deduplicator top level: tile store, match flag memory and row scan sequencer.
//
//   channel | direction | handshake             | word
//   in_     | input     | in_valid / in_ready   | tdd_pkg::in_word_t
//   out_    | output    | out_valid / out_ready | tdd_pkg::out_word_t
//   cfg_    | input     | cfg_we                | dedup_enable in cfg_wdata
//
// Each row goes through these steps: accept and write the row, one read per stored
// tile on the store's single read port, compare the last read, leave the scan and
// finish. No clearing pass: flags are ignored on a tile's first row and only written
// store rows are read.
// Rows are taken while a result waits; the eighth row holds in its finish step
// until the output register is free.
`timescale 1ns / 1ps

module tile_deduplicator #(
  parameter int MAX_TILES = tdd_pkg::MAX_TILES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tdd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tdd_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  localparam int TIW   = $clog2(MAX_TILES);
  localparam int UCW   = $clog2(MAX_TILES + 1);
  localparam int AW    = TIW + 3;
  localparam int DEPTH = MAX_TILES * tdd_pkg::TILE_ROWS;
  localparam logic [UCW-1:0] UC_MAX = UCW'(MAX_TILES);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t               st_r;
  logic [2:0]           row_cnt_r;
  logic [UCW-1:0]       uc_r;
  logic [tdd_pkg::ROW_W-1:0] cur_row_r;
  logic [2:0]           cur_r_r;
  logic                 eoi_r;
  logic [UCW-1:0]       iss_i_r;
  logic                 rd_vld_r;
  logic [TIW-1:0]       rd_i_r;
  logic                 found_r;
  logic [TIW-1:0]       found_i_r;
  logic                 dedup_r;
  logic                 out_valid_r;
  tdd_pkg::out_word_t   out_data_r;

  logic [tdd_pkg::ROW_W-1:0] tile_mem [0:DEPTH-1];
  logic                      flag_mem [0:MAX_TILES-1];
  logic [tdd_pkg::ROW_W-1:0] tile_rd_r;
  logic                      flag_rd_r;

  logic               accept;
  logic               store_wr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               match;
  tdd_pkg::out_word_t res;
  logic [UCW-1:0]     uc_after;

  assign in_ready  = (st_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign store_wr  = accept && (uc_r < UC_MAX);
  assign wr_addr   = {uc_r[TIW-1:0], row_cnt_r};
  assign rd_en     = (st_r == ST_SCAN) && (iss_i_r < uc_r);
  assign rd_addr   = {iss_i_r[TIW-1:0], cur_r_r};
  // first row of a tile starts every flag set
  assign match     = (tile_rd_r == cur_row_r) && ((cur_r_r == 3'd0) || flag_rd_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (store_wr) begin
      tile_mem[wr_addr] <= in_data.row_pixels;
    end
    if (rd_en) begin
      tile_rd_r <= tile_mem[rd_addr];
      flag_rd_r <= flag_mem[iss_i_r[TIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      flag_mem[rd_i_r] <= match;
    end
  end

  always_comb begin
    res      = '0;
    uc_after = uc_r;
    if (dedup_r && found_r) begin
      res.tile_index = 8'(found_i_r);
    end else if (uc_r < UC_MAX) begin
      res.tile_index = 8'(uc_r);
      res.is_new     = 1'b1;
      uc_after       = uc_r + UCW'(1);
    end else begin
      res.overflow   = 1'b1;
    end
    res.tile_count = 9'(uc_after);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      row_cnt_r   <= 3'd0;
      uc_r        <= '0;
      iss_i_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      dedup_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dedup_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= rd_en;
      if (rd_en) begin
        rd_i_r  <= iss_i_r[TIW-1:0];
        iss_i_r <= iss_i_r + UCW'(1);
      end
      // record the lowest tile still matching after the last row
      if (rd_vld_r && match && (cur_r_r == 3'd7) && !found_r) begin
        found_r   <= 1'b1;
        found_i_r <= rd_i_r;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (accept) begin
            cur_row_r <= in_data.row_pixels;
            eoi_r     <= in_data.end_of_image;
            cur_r_r   <= row_cnt_r;
            iss_i_r   <= '0;
            found_r   <= 1'b0;
            st_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!rd_en && !rd_vld_r) begin
            st_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (cur_r_r == 3'd7) begin
            // hold until the output register is free
            if (!out_valid_r) begin
              out_valid_r <= 1'b1;
              out_data_r  <= res;
              uc_r        <= eoi_r ? '0 : uc_after;
              row_cnt_r   <= 3'd0;
              st_r        <= ST_IDLE;
            end
          end else begin
            row_cnt_r <= eoi_r ? 3'd0 : cur_r_r + 3'd1;
            if (eoi_r) begin
              uc_r <= '0;
            end
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule
